### design/spwq_pkg.sv
`timescale 1ns / 1ps
package spwq_pkg;

	localparam int WAIT_SLOTS_DEF = 16;
	localparam int ID_W           = 4;
	localparam int PRIO_W         = 8;
	localparam int COUNT_W        = 8;
	localparam int STATUS_W       = 3;
	localparam int WAITERS_W      = 5;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CNT  = 2'd3;

	typedef enum logic [1:0] {
		OP_LOCK   = 2'd0,
		OP_UNLOCK = 2'd1,
		OP_CANCEL = 2'd2,
		OP_CREATE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_QUEUED      = 3'd1,
		ST_NOT_CREATED = 3'd2,
		ST_FULL        = 3'd3,
		ST_NOT_FOUND   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_UPD
	} fsm_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_POP
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t           cmd;
		logic                prio_order;
		logic                cmp_en;
		logic [ID_W-1:0]     req_id;
		logic [PRIO_W-1:0]   req_prio;
	} cell_ctl_t;

endpackage

### design/semaphore_priority_wait_queue_core.sv
`timescale 1ns / 1ps
// channel   signals                              payload
// in        in_valid / in_ready                  opcode, thread_id, priority_req
// out       out_valid / out_ready                status, wake_valid, wake_thread,
//                                                count_now, waiters_now
// cfg       cfg_we, cfg_index, cfg_data          write only, no handshake
//
// each request passes accept, then a compare pass in every cell of the waiter
// row, then an update pass; an insert, pop or matched cancel shifts it one place
// the update waits while the previous response is still unclaimed
// in_ready is high whenever no request is in flight, even with a response held
// reset clears control state only; row contents are unknown until written
module semaphore_priority_wait_queue_core #(
	parameter int WAIT_SLOTS = spwq_pkg::WAIT_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic [spwq_pkg::ID_W-1:0]         thread_id,
	input  logic [spwq_pkg::PRIO_W-1:0]       priority_req,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [spwq_pkg::STATUS_W-1:0]     status,
	output logic                              wake_valid,
	output logic [spwq_pkg::ID_W-1:0]         wake_thread,
	output logic [spwq_pkg::COUNT_W-1:0]      count_now,
	output logic [spwq_pkg::WAITERS_W-1:0]    waiters_now,
	input  logic                              cfg_we,
	input  logic [spwq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spwq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CNT_W = $clog2(WAIT_SLOTS + 1);
	localparam int ID_W  = spwq_pkg::ID_W;
	localparam int PR_W  = spwq_pkg::PRIO_W;
	localparam int CT_W  = spwq_pkg::COUNT_W;

	logic                  semaphore_mode_q;
	logic                  priority_order_q;
	logic [CT_W-1:0]       initial_count_q;
	logic [CT_W-1:0]       max_count_q;

	spwq_pkg::fsm_t        state_q, state_d;
	logic                  created_q, created_d;
	logic [CT_W-1:0]       avail_q, avail_d;
	logic [CNT_W-1:0]      count_q, count_d;

	spwq_pkg::op_t         req_op_q;
	logic [ID_W-1:0]       req_id_q;
	logic [PR_W-1:0]       req_prio_q;

	logic                  out_valid_q;
	spwq_pkg::status_t     status_q, status_d;
	logic                  wake_valid_q, wake_valid_d;
	logic [ID_W-1:0]       wake_thread_q, wake_thread_d;
	logic [CT_W-1:0]       count_now_q;
	logic [CNT_W-1:0]      waiters_q;

	spwq_pkg::cell_ctl_t   ctl;
	spwq_pkg::cell_cmd_t   cmd;
	logic                  upd;

	logic [ID_W-1:0]       cell_id   [WAIT_SLOTS];
	logic [PR_W-1:0]       cell_prio [WAIT_SLOTS];
	logic [WAIT_SLOTS:0]   chain;

	assign chain[0] = 1'b0;

	for (genvar g = 0; g < WAIT_SLOTS; g++) begin : g_row
		logic [ID_W-1:0] prev_id, next_id;
		logic [PR_W-1:0] prev_prio, next_prio;
		if (g == 0) begin : g_first
			assign prev_id   = req_id_q;
			assign prev_prio = req_prio_q;
		end else begin : g_mid
			assign prev_id   = cell_id[g-1];
			assign prev_prio = cell_prio[g-1];
		end
		if (g == WAIT_SLOTS - 1) begin : g_last
			assign next_id   = cell_id[g];
			assign next_prio = cell_prio[g];
		end else begin : g_inner
			assign next_id   = cell_id[g+1];
			assign next_prio = cell_prio[g+1];
		end
		spwq_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.prev_id    (prev_id),
			.prev_prio  (prev_prio),
			.next_id    (next_id),
			.next_prio  (next_prio),
			.before_in  (chain[g]),
			.id         (cell_id[g]),
			.prio       (cell_prio[g]),
			.before_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			semaphore_mode_q <= 1'b0;
			priority_order_q <= 1'b0;
			initial_count_q  <= CT_W'(1);
			max_count_q      <= CT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				spwq_pkg::REG_MODE:     semaphore_mode_q <= cfg_data[0];
				spwq_pkg::REG_ORDER:    priority_order_q <= cfg_data[0];
				spwq_pkg::REG_INIT_CNT: initial_count_q  <= cfg_data;
				spwq_pkg::REG_MAX_CNT:  max_count_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d       = state_q;
		created_d     = created_q;
		avail_d       = avail_q;
		count_d       = count_q;
		status_d      = spwq_pkg::ST_OK;
		wake_valid_d  = 1'b0;
		wake_thread_d = '0;
		cmd           = spwq_pkg::CMD_NONE;
		upd           = 1'b0;
		in_ready      = 1'b0;
		unique case (state_q)
			spwq_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = spwq_pkg::FSM_CMP;
				end
			end
			spwq_pkg::FSM_CMP: begin
				// the response slot is free next cycle if empty or being taken now
				if (!out_valid_q || out_ready) begin
					state_d = spwq_pkg::FSM_UPD;
				end
			end
			spwq_pkg::FSM_UPD: begin
				upd     = 1'b1;
				state_d = spwq_pkg::FSM_IDLE;
				if (req_op_q == spwq_pkg::OP_CREATE) begin
					count_d   = '0;
					created_d = 1'b1;
					avail_d   = semaphore_mode_q ? initial_count_q : CT_W'(1);
				end else if (!created_q) begin
					status_d = spwq_pkg::ST_NOT_CREATED;
				end else begin
					unique case (req_op_q)
						spwq_pkg::OP_LOCK: begin
							if (avail_q != '0) begin
								avail_d = avail_q - CT_W'(1);
							end else if (count_q == CNT_W'(WAIT_SLOTS)) begin
								status_d = spwq_pkg::ST_FULL;
							end else begin
								cmd      = spwq_pkg::CMD_INSERT;
								count_d  = count_q + CNT_W'(1);
								status_d = spwq_pkg::ST_QUEUED;
							end
						end
						spwq_pkg::OP_UNLOCK: begin
							if (avail_q != '0) begin
								if (!semaphore_mode_q) begin
									avail_d = CT_W'(1);
								end else if (avail_q < max_count_q) begin
									avail_d = avail_q + CT_W'(1);
								end
							end else if (count_q == '0) begin
								avail_d = CT_W'(1);
							end else begin
								cmd           = spwq_pkg::CMD_POP;
								count_d       = count_q - CNT_W'(1);
								wake_valid_d  = 1'b1;
								wake_thread_d = cell_id[0];
							end
						end
						spwq_pkg::OP_CANCEL: begin
							// cells act only where the match chain has fired
							cmd = spwq_pkg::CMD_REMOVE;
							if (chain[WAIT_SLOTS]) begin
								count_d = count_q - CNT_W'(1);
							end else begin
								status_d = spwq_pkg::ST_NOT_FOUND;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: state_d = spwq_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.cmd        = cmd;
		ctl.prio_order = priority_order_q;
		ctl.cmp_en     = state_q == spwq_pkg::FSM_CMP;
		ctl.req_id     = req_id_q;
		ctl.req_prio   = req_prio_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spwq_pkg::FSM_IDLE;
			created_q   <= 1'b0;
			avail_q     <= CT_W'(1);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			created_q <= created_d;
			avail_q   <= avail_d;
			count_q   <= count_d;
			if (upd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_op_q   <= spwq_pkg::op_t'(opcode);
			req_id_q   <= thread_id;
			req_prio_q <= priority_req;
		end
		if (upd) begin
			status_q      <= status_d;
			wake_valid_q  <= wake_valid_d;
			wake_thread_q <= wake_thread_d;
			count_now_q   <= avail_d;
			waiters_q     <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign wake_valid  = wake_valid_q;
	assign wake_thread = wake_thread_q;
	assign count_now   = count_now_q;
	assign waiters_now = spwq_pkg::WAITERS_W'(waiters_q);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WAIT_SLOTS))
		else $error("waiter count beyond number of slots");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spwq_pkg::FSM_UPD) |-> !out_valid_q)
		else $error("update with response slot still occupied");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != spwq_pkg::FSM_UPD) |=> $stable(count_q))
		else $error("waiter count moved outside update");

	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wake_valid_q) |-> (status_q == spwq_pkg::ST_OK))
		else $error("wake reported with non-ok status");

	a_wake_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && wake_valid_d) |-> (count_q != '0 && avail_q == '0))
		else $error("wake from empty queue or with units free");
`endif

endmodule

### design/spwq_cell.sv
`timescale 1ns / 1ps
module spwq_cell #(
	parameter int IDX     = 0,
	parameter int CNT_W   = 5
) (
	input  logic                          clk,
	input  spwq_pkg::cell_ctl_t           ctl,
	input  logic [CNT_W-1:0]              count,
	input  logic [spwq_pkg::ID_W-1:0]     prev_id,
	input  logic [spwq_pkg::PRIO_W-1:0]   prev_prio,
	input  logic [spwq_pkg::ID_W-1:0]     next_id,
	input  logic [spwq_pkg::PRIO_W-1:0]   next_prio,
	input  logic                          before_in,
	output logic [spwq_pkg::ID_W-1:0]     id,
	output logic [spwq_pkg::PRIO_W-1:0]   prio,
	output logic                          before_out
);

	logic [spwq_pkg::ID_W-1:0]   id_q;
	logic [spwq_pkg::PRIO_W-1:0] prio_q;
	logic                        gt_q;
	logic                        eq_q;
	logic                        occ;
	logic                        at_tail;
	logic                        hit;

	assign occ     = count > CNT_W'(IDX);
	assign at_tail = count == CNT_W'(IDX);

	always_comb begin
		case (ctl.cmd)
			spwq_pkg::CMD_INSERT: hit = occ & ctl.prio_order & gt_q;
			spwq_pkg::CMD_REMOVE: hit = occ & eq_q;
			default:              hit = 1'b0;
		endcase
	end

	// first hit along the row decides where the row opens or closes
	assign before_out = before_in | hit;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			gt_q <= ctl.req_prio > prio_q;
			eq_q <= ctl.req_id == id_q;
		end
		case (ctl.cmd)
			spwq_pkg::CMD_INSERT: begin
				if (before_in) begin
					id_q   <= prev_id;
					prio_q <= prev_prio;
				end else if (hit || at_tail) begin
					id_q   <= ctl.req_id;
					prio_q <= ctl.req_prio;
				end
			end
			spwq_pkg::CMD_REMOVE: begin
				if (before_in || hit) begin
					id_q   <= next_id;
					prio_q <= next_prio;
				end
			end
			spwq_pkg::CMD_POP: begin
				id_q   <= next_id;
				prio_q <= next_prio;
			end
			default: begin
			end
		endcase
	end

	assign id   = id_q;
	assign prio = prio_q;

endmodule
